// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define HS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define HS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/hs_pkg.sv -----
// ----------------------------------------------------------------------------
// hs_pkg
// Widths, types and controller commands shared by the heap sorter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hs_pkg;

  localparam int unsigned MaxItems = 64;
  localparam int unsigned DataW    = 32;
  localparam int unsigned AddrW    = $clog2(MaxItems);
  localparam int unsigned CntW     = $clog2(MaxItems + 1);
  localparam int unsigned IdxW     = AddrW + 2;

  typedef logic [DataW-1:0] data_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [IdxW-1:0]  idx_t;

  typedef enum logic [11:0] {
    OP_LOAD     = 12'b0000_0000_0001,
    OP_BLD      = 12'b0000_0000_0010,
    OP_BLD_HOLD = 12'b0000_0000_0100,
    OP_XT       = 12'b0000_0000_1000,
    OP_XT_ROOT  = 12'b0000_0001_0000,
    OP_XT_MOVE  = 12'b0000_0010_0000,
    OP_SFT_L    = 12'b0000_0100_0000,
    OP_SFT_R    = 12'b0000_1000_0000,
    OP_SFT_CMP  = 12'b0001_0000_0000,
    OP_EM_RD    = 12'b0010_0000_0000,
    OP_EM_LD    = 12'b0100_0000_0000,
    OP_EM_WAIT  = 12'b1000_0000_0000
  } hs_op_e;

  typedef struct packed {
    hs_op_e op;
  } hs_cmd_t;

  typedef struct packed {
    logic batch_close;
    logic k_zero;
    logic k_le1;
    logic l_ok;
    logic moving;
    logic out_fire;
    logic run_done;
  } hs_stat_t;

endpackage

`default_nettype wire

// ----- rtl/hs_ram.sv -----
// ----------------------------------------------------------------------------
// hs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/hs_ctrl.sv -----
// ----------------------------------------------------------------------------
// hs_ctrl
// Sequencer for load, heap build, extraction and output of a batch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hs_ctrl import hs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire hs_stat_t stat_i,
  output hs_cmd_t       cmd_o
);

  hs_op_e state_q, state_d;
  logic   extract_q, extract_d;

  always_comb begin
    state_d   = state_q;
    extract_d = extract_q;
    unique case (state_q)
      OP_LOAD: begin
        if (stat_i.batch_close) begin
          state_d   = OP_BLD;
          extract_d = 1'b0;
        end
      end
      OP_BLD: begin
        if (stat_i.k_zero) begin
          state_d   = OP_XT;
          extract_d = 1'b1;
        end else begin
          state_d = OP_BLD_HOLD;
        end
      end
      OP_BLD_HOLD: state_d = OP_SFT_L;
      OP_XT:       state_d = stat_i.k_le1 ? OP_EM_RD : OP_XT_ROOT;
      OP_XT_ROOT:  state_d = OP_XT_MOVE;
      OP_XT_MOVE:  state_d = OP_SFT_L;
      OP_SFT_L: begin
        if (stat_i.l_ok) begin
          state_d = OP_SFT_R;
        end else begin
          state_d = extract_q ? OP_XT : OP_BLD;
        end
      end
      OP_SFT_R: state_d = OP_SFT_CMP;
      OP_SFT_CMP: begin
        if (stat_i.moving) begin
          state_d = OP_SFT_L;
        end else begin
          state_d = extract_q ? OP_XT : OP_BLD;
        end
      end
      OP_EM_RD: state_d = OP_EM_LD;
      OP_EM_LD: state_d = OP_EM_WAIT;
      OP_EM_WAIT: begin
        if (stat_i.out_fire) begin
          state_d = stat_i.run_done ? OP_LOAD : OP_EM_RD;
        end
      end
      default: state_d = OP_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= OP_LOAD;
      extract_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      extract_q <= extract_d;
    end
  end

  assign cmd_o.op = state_q;

endmodule

`default_nettype wire

// ----- rtl/hs_dp.sv -----
// ----------------------------------------------------------------------------
// hs_dp
// Value store, heap indexes, sift compare and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hs_dp import hs_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire hs_cmd_t cmd_i,
  input  wire logic    item_valid_i,
  output logic         item_ready_o,
  input  wire data_t   item_value_i,
  input  wire logic    item_last_i,
  output logic         sorted_valid_o,
  input  wire logic    sorted_ready_i,
  output data_t        sorted_value_o,
  output logic         run_end_o,
  output hs_stat_t     stat_o
);

  cnt_t  cnt_q, cnt_d;
  cnt_t  k_q, k_d;
  cnt_t  hn_q, hn_d;
  addr_t pos_q, pos_d;
  logic  out_valid_q, out_valid_d;
  data_t val_q, val_d;
  data_t lval_q, lval_d;
  data_t out_value_q, out_value_d;
  logic  out_last_q, out_last_d;

  logic  ram_we;
  addr_t ram_waddr;
  data_t ram_wdata;
  addr_t ram_raddr;
  data_t ram_rdata;

  idx_t  l_idx, r_idx, hn_idx;
  logic  l_ok, r_ok, go_l, go_r, moving;
  data_t best_val;
  cnt_t  cnt_inc, k_dec;
  logic  in_fire, out_fire, batch_close;

  assign l_idx  = {1'b0, pos_q, 1'b1};
  assign r_idx  = l_idx + idx_t'(1);
  assign hn_idx = idx_t'(hn_q);
  assign l_ok   = l_idx < hn_idx;
  assign r_ok   = r_idx < hn_idx;

  assign go_l     = $signed(val_q) < $signed(lval_q);
  assign best_val = go_l ? lval_q : val_q;
  assign go_r     = r_ok && ($signed(best_val) < $signed(ram_rdata));
  assign moving   = go_l || go_r;

  assign cnt_inc = cnt_q + cnt_t'(1);
  assign k_dec   = k_q - cnt_t'(1);

  assign item_ready_o = (cmd_i.op == OP_LOAD);
  assign in_fire      = item_valid_i && item_ready_o;
  assign out_fire     = out_valid_q && sorted_ready_i;
  assign batch_close  = in_fire && (item_last_i || (cnt_q == cnt_t'(MaxItems - 1)));

  always_comb begin
    cnt_d       = cnt_q;
    k_d         = k_q;
    hn_d        = hn_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    val_d       = val_q;
    lval_d      = lval_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = val_q;
    ram_raddr   = '0;
    unique case (cmd_i.op)
      OP_LOAD: begin
        if (in_fire) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AddrW-1:0];
          ram_wdata = item_value_i;
          cnt_d     = cnt_inc;
          k_d       = cnt_inc >> 1;
        end
      end
      OP_BLD: begin
        if (k_q == '0) begin
          k_d = cnt_q;
        end else begin
          ram_raddr = k_dec[AddrW-1:0];
          pos_d     = k_dec[AddrW-1:0];
          hn_d      = cnt_q;
        end
      end
      OP_BLD_HOLD: val_d = ram_rdata;
      OP_XT: begin
        if (k_q <= cnt_t'(1)) begin
          k_d = '0;
        end else begin
          ram_raddr = k_dec[AddrW-1:0];
        end
      end
      OP_XT_ROOT: begin
        val_d     = ram_rdata;
        ram_raddr = '0;
      end
      OP_XT_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = k_dec[AddrW-1:0];
        ram_wdata = ram_rdata;
        pos_d     = '0;
        hn_d      = k_dec;
      end
      OP_SFT_L: begin
        if (l_ok) begin
          ram_raddr = l_idx[AddrW-1:0];
        end else begin
          ram_we = 1'b1;
          k_d    = k_dec;
        end
      end
      OP_SFT_R: begin
        lval_d    = ram_rdata;
        ram_raddr = r_idx[AddrW-1:0];
      end
      OP_SFT_CMP: begin
        ram_we = 1'b1;
        if (go_r) begin
          ram_wdata = ram_rdata;
          pos_d     = r_idx[AddrW-1:0];
        end else if (go_l) begin
          ram_wdata = lval_q;
          pos_d     = l_idx[AddrW-1:0];
        end else begin
          k_d = k_dec;
        end
      end
      OP_EM_RD: ram_raddr = k_q[AddrW-1:0];
      OP_EM_LD: begin
        out_value_d = ram_rdata;
        out_last_d  = ((k_q + cnt_t'(1)) == cnt_q);
        out_valid_d = 1'b1;
      end
      OP_EM_WAIT: begin
        if (out_fire) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d = '0;
          end else begin
            k_d = k_q + cnt_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      k_q         <= '0;
      hn_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      hn_q        <= hn_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    lval_q      <= lval_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  hs_ram #(
    .Width(DataW),
    .Depth(MaxItems)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign sorted_valid_o = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign run_end_o      = out_last_q;

  assign stat_o.batch_close = batch_close;
  assign stat_o.k_zero      = (k_q == '0);
  assign stat_o.k_le1       = (k_q <= cnt_t'(1));
  assign stat_o.l_ok        = l_ok;
  assign stat_o.moving      = moving;
  assign stat_o.out_fire    = out_fire;
  assign stat_o.run_done    = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/heap_sorter_unit.sv -----
// ----------------------------------------------------------------------------
// heap_sorter_unit
// Batch heapsort of signed 32-bit values with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel takes one value per transfer into the store, one cycle
//   each. A transfer with item_last_i set, or the 64th transfer, closes the
//   batch; item_ready_o then stays low until the whole batch has left.
//   The batch is sorted in place by heapsort: each sift level on the store
//   reads the left child, then the right child, then compares and writes.
//   The sorted channel then gives the values in ascending order, one at a
//   time: each is read, loaded into the output register and held until
//   taken before the next is read; run_end_o marks the largest, final
//   value. A stalled receiver holds the output register and the
//   sequencer. Reset empties the batch and drops any pending output; the
//   store needs no clearing since only values written in the current
//   batch are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heap_sorter_unit import hs_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  output logic       item_ready_o,
  input  wire data_t item_value_i,
  input  wire logic  item_last_i,
  output logic       sorted_valid_o,
  input  wire logic  sorted_ready_i,
  output data_t      sorted_value_o,
  output logic       run_end_o
);

  hs_cmd_t  cmd;
  hs_stat_t stat;

  hs_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  hs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .item_valid_i  (item_valid_i),
    .item_ready_o  (item_ready_o),
    .item_value_i  (item_value_i),
    .item_last_i   (item_last_i),
    .sorted_valid_o(sorted_valid_o),
    .sorted_ready_i(sorted_ready_i),
    .sorted_value_o(sorted_value_o),
    .run_end_o     (run_end_o),
    .stat_o        (stat)
  );

endmodule

`default_nettype wire

// ----- rtl/hs_checker.sv -----
// ----------------------------------------------------------------------------
// hs_checker
// Port-level checks on the heap sorter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hs_checker import hs_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  item_ready_i,
  input wire logic  sorted_valid_i,
  input wire logic  sorted_ready_i,
  input wire data_t sorted_value_i,
  input wire logic  run_end_i
);

  logic  out_fire;
  data_t prev_q;
  logic  prev_valid_q;

  assign out_fire = sorted_valid_i && sorted_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
    end else if (out_fire) begin
      prev_valid_q <= !run_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      prev_q <= sorted_value_i;
    end
  end

  `HS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, sorted_valid_i && !sorted_ready_i, sorted_valid_i && $stable(sorted_value_i) && $stable(run_end_i))
  `HS_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, sorted_valid_i, !item_ready_i)
  `HS_ASSERT_IMP(a_ascending, clk_i, rst_ni, out_fire && prev_valid_q, $signed(sorted_value_i) >= $signed(prev_q))
  `HS_ASSERT_NXT(a_reload, clk_i, rst_ni, out_fire && run_end_i, item_ready_i && !sorted_valid_i)

endmodule

bind heap_sorter_unit hs_checker u_hs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .item_ready_i  (item_ready_o),
  .sorted_valid_i(sorted_valid_o),
  .sorted_ready_i(sorted_ready_i),
  .sorted_value_i(sorted_value_o),
  .run_end_i     (run_end_o)
);

`default_nettype wire
